/* rtl/rhfld_pkg.sv */
// ----------------------------------------------------------------------------
// rhfld_pkg
// Shared types, character codes and helper functions for the raw hex frame
// line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rhfld_pkg;

  // Default number of decoded bytes a line may carry
  localparam int MAX_BYTES_DEF = 14;

  // Character codes
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;

  // Line status codes
  typedef enum logic [2:0] {
    ST_GOOD       = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_FRAMED = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_BAD_HEX    = 3'd4
  } status_t;

  // Result sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } rhfld_state_t;

  // Whitespace: space, and tab up to and including carriage return
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SP) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

`default_nettype wire

/* rtl/rhfld_in_if.sv */
// ----------------------------------------------------------------------------
// rhfld_in_if
// Character input channel: valid/ready handshake carrying one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhfld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/rhfld_out_if.sv */
// ----------------------------------------------------------------------------
// rhfld_out_if
// Result channel: valid/ready handshake carrying one decoded result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhfld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_byte;
  logic       byte_valid;
  logic       last_of_line;
  logic [3:0] frame_length;

  modport source (output valid, output status, output frame_byte, output byte_valid,
                  output last_of_line, output frame_length, input ready);
  modport sink   (input valid, input status, input frame_byte, input byte_valid,
                  input last_of_line, input frame_length, output ready);
endinterface

`default_nettype wire

/* rtl/raw_hex_frame_line_decoder.sv */
// ----------------------------------------------------------------------------
// raw_hex_frame_line_decoder
// Decodes framed hex text lines ('*' hex digits ... ';') into binary bytes,
// one result per byte at the end of each line, or one status result.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  in_ch     in   valid/ready    in_byte
//  out_ch    out  valid/ready    status, frame_byte, byte_valid,
//                                last_of_line, frame_length
//
// A character is taken every cycle while no line result is pending.
// At the newline the input stalls while results go out: a good line with
// N bytes gives N results, each a byte store read (S_READ) then an output
// state (S_SHOW), any other line a single result; downstream stalls hold it.
// Reset (synchronous, rst) clears the line state and sequencer; the byte
// store is not cleared, as only bytes written in the current line are read.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_hex_frame_line_decoder
  import rhfld_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rhfld_in_if.sink    in_ch,
  rhfld_out_if.source out_ch
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);

  rhfld_state_t  state;
  rhfld_state_t  state_next;

  status_t       res_status;
  logic [CW-1:0] res_count;
  logic [CW-1:0] idx;
  logic          has_bytes;

  logic          in_fire;
  logic          out_fire;
  logic          is_nl;
  logic          is_last;
  logic [CW+3:0] len_ext;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rd_data;
  status_t       line_status;
  logic [CW-1:0] line_count;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign is_nl    = (in_ch.in_byte == CHAR_LF);
  assign is_last  = !has_bytes || ({1'b0, idx} + (CW + 1)'(1) == {1'b0, res_count});
  assign len_ext  = {4'b0000, res_count};

  rhfld_line_parse #(
    .MAX_BYTES (MAX_BYTES),
    .AW        (AW),
    .CW        (CW)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .in_byte     (in_ch.in_byte),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .line_status (line_status),
    .line_count  (line_count)
  );

  rhfld_byte_mem #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && is_nl) begin
          if ((line_status == ST_GOOD) && (line_count != '0)) begin
            state_next = S_READ;
          end else begin
            state_next = S_SHOW;
          end
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        out_ch.valid = 1'b1;
        if (out_fire) begin
          state_next = is_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Latch the line summary at the newline; advance the byte index per result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire && is_nl) begin
      res_status <= line_status;
      res_count  <= line_count;
      has_bytes  <= (line_status == ST_GOOD) && (line_count != '0);
      idx        <= '0;
    end else if (state == S_SHOW && out_fire && !is_last) begin
      idx <= idx + CW'(1);
    end
  end

  // Result payload
  assign out_ch.status       = res_status;
  assign out_ch.frame_byte   = has_bytes ? rd_data : 8'h00;
  assign out_ch.byte_valid   = has_bytes;
  assign out_ch.last_of_line = is_last;
  assign out_ch.frame_length = has_bytes ? len_ext[3:0] : 4'h0;

endmodule

`default_nettype wire

/* rtl/rhfld_byte_mem.sv */
// ----------------------------------------------------------------------------
// rhfld_byte_mem
// Byte store for one line: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rhfld_byte_mem #(
  parameter int DEPTH = 14,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write decoded bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rhfld_line_parse.sv */
// ----------------------------------------------------------------------------
// rhfld_line_parse
// Per-line scanner: trims whitespace, tracks framing, pairs hex digits into
// bytes for the byte store, and reports the line status at the newline.
// ----------------------------------------------------------------------------
`default_nettype none

module rhfld_line_parse
  import rhfld_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  parameter int AW        = 4,
  parameter int CW        = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_byte,
  output logic               wr_en,
  output logic      [AW-1:0] wr_addr,
  output logic      [7:0]    wr_data,
  output status_t            line_status,
  output logic      [CW-1:0] line_count
);

  localparam int LEN_CAP = 2 * MAX_BYTES + 3;
  localparam int LW      = $clog2(LEN_CAP + 1);

  logic [CW-1:0] count;
  logic [LW-1:0] clen;
  logic [LW-1:0] pend;
  logic [3:0]    high;
  logic          npend;
  logic          star;
  logic          semi;
  logic [7:0]    tent;
  logic          bad;

  logic          is_nl;
  logic          is_sp;
  logic          take_char;
  logic          do_mid;
  logic [4:0]    hv;
  logic [LW:0]   total;

  assign is_nl     = (in_byte == CHAR_LF);
  assign is_sp     = is_space(in_byte);
  assign take_char = in_fire && !is_nl && !is_sp;
  assign do_mid    = take_char && (clen >= LW'(2));
  assign hv        = hex_value(tent);
  assign total     = {1'b0, clen} + {1'b0, pend} + (LW + 1)'(1);

  // Store a byte when the held character completes a digit pair
  assign wr_en   = do_mid && hv[4] && npend && (count < CW'(MAX_BYTES));
  assign wr_addr = count[AW-1:0];
  assign wr_data = {high, hv[3:0]};

  // Line status: the first failing check wins
  always_comb begin
    if (clen < LW'(2)) begin
      line_status = ST_EMPTY;
    end else if (!star || !semi) begin
      line_status = ST_NOT_FRAMED;
    end else if (clen > LW'(2 * MAX_BYTES + 2)) begin
      line_status = ST_TOO_LONG;
    end else if (bad || clen[0]) begin
      line_status = ST_BAD_HEX;
    end else begin
      line_status = ST_GOOD;
    end
  end

  assign line_count = count;

  // Advance the line state; clear it at the newline
  always_ff @(posedge clk) begin
    if (rst || (in_fire && is_nl)) begin
      count <= '0;
      clen  <= '0;
      pend  <= '0;
      high  <= '0;
      npend <= 1'b0;
      star  <= 1'b0;
      semi  <= 1'b0;
      tent  <= '0;
      bad   <= 1'b0;
    end else if (in_fire && is_sp) begin
      if ((clen != '0) && (pend < LW'(LEN_CAP))) begin
        pend <= pend + LW'(1);
      end
    end else if (take_char) begin
      if (in_byte == CHAR_SEMI) begin
        semi <= 1'b1;
      end
      tent <= in_byte;
      if (clen == '0) begin
        star <= (in_byte == CHAR_STAR);
        clen <= LW'(1);
      end else begin
        // Held character becomes interior: decode it
        if (do_mid) begin
          if (!hv[4]) begin
            bad <= 1'b1;
          end else if (npend) begin
            if (count < CW'(MAX_BYTES)) begin
              count <= count + CW'(1);
            end
            npend <= 1'b0;
          end else begin
            high  <= hv[3:0];
            npend <= 1'b1;
          end
        end
        // Interior whitespace is never a hex digit
        if (pend != '0) begin
          bad <= 1'b1;
        end
        clen <= (total > (LW + 1)'(LEN_CAP)) ? LW'(LEN_CAP) : total[LW-1:0];
        pend <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raw hex frame line decoder. Text lines are
// fed one character per transaction with random source gaps and sink
// stalls. A line-level predictor tracks trimming, framing, length and hex
// checks and queues the results each newline should produce. Every result
// transaction is compared against the oldest queued one.
// ----------------------------------------------------------------------------

module tb_top;
  import rhfld_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int MAX_BYTES   = MAX_BYTES_DEF;
  localparam int LEN_CAP     = 2 * MAX_BYTES + 3;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       last_of_line;
    logic [3:0] frame_length;
  } line_result_t;

  typedef enum {
    LN_GOOD,
    LN_MUTATED,
    LN_NO_SEMI,
    LN_ODD,
    LN_LONG,
    LN_NOISE
  } line_kind_t;

  logic clk;
  logic rst;

  rhfld_in_if  in_ch ();
  rhfld_out_if out_ch ();

  raw_hex_frame_line_decoder #(
    .MAX_BYTES (MAX_BYTES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Line decoder shadow state
  logic [7:0] decoded [MAX_BYTES];
  int         decoded_count;
  int         trim_len;
  int         held_spaces;
  logic [3:0] hi_nibble;
  logic       nibble_half;
  logic       star_first;
  logic       semi_seen;
  logic [7:0] last_char;
  logic       middle_bad;

  line_result_t expected_results [$];
  logic [7:0]   line_buf [$];

  int mismatch_count    = 0;
  int chars_sent        = 0;
  int results_predicted = 0;
  int cycle_count       = 0;
  bit src_gaps_on       = 1'b1;
  bit sink_gaps_on      = 1'b1;

  // Clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Value of a hex digit, or -1 for anything else
  function automatic int digit_value(input logic [7:0] c);
    if ((c >= "0") && (c <= "9")) return int'(c) - int'("0");
    if ((c >= "a") && (c <= "f")) return int'(c) - int'("a") + 10;
    if ((c >= "A") && (c <= "F")) return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void clear_line_state();
    decoded_count = 0;
    trim_len      = 0;
    held_spaces   = 0;
    hi_nibble     = '0;
    nibble_half   = 1'b0;
    star_first    = 1'b0;
    semi_seen     = 1'b0;
    last_char     = '0;
    middle_bad    = 1'b0;
  endfunction

  // Consume one character lying between the first and the last
  function automatic void take_middle(input logic [7:0] c);
    int v;
    v = digit_value(c);
    if (v < 0) begin
      middle_bad = 1'b1;
    end else if (nibble_half) begin
      if (decoded_count < MAX_BYTES) begin
        decoded[decoded_count] = {hi_nibble, v[3:0]};
        decoded_count++;
      end
      nibble_half = 1'b0;
    end else begin
      hi_nibble   = v[3:0];
      nibble_half = 1'b1;
    end
  endfunction

  function automatic void push_result(input line_result_t r);
    expected_results.push_back(r);
    results_predicted++;
  endfunction

  // Advance the line state by one accepted character
  function automatic void decode_char(input logic [7:0] c);
    status_t st;
    if (c == CHAR_LF) begin
      if (trim_len < 2)                         st = ST_EMPTY;
      else if (!star_first || !semi_seen)       st = ST_NOT_FRAMED;
      else if (trim_len - 2 > 2 * MAX_BYTES)    st = ST_TOO_LONG;
      else if (middle_bad || (trim_len % 2 != 0)) st = ST_BAD_HEX;
      else                                      st = ST_GOOD;
      if ((st != ST_GOOD) || (decoded_count == 0)) begin
        push_result('{st, 8'h00, 1'b0, 1'b1, 4'd0});
      end else begin
        for (int k = 0; k < decoded_count; k++) begin
          push_result('{ST_GOOD, decoded[k], 1'b1, (k == decoded_count - 1),
                        4'(decoded_count)});
        end
      end
      clear_line_state();
    end else if (is_blank(c)) begin
      // Trailing blanks stay pending until a later character makes them interior
      if ((trim_len > 0) && (held_spaces < LEN_CAP)) held_spaces++;
    end else begin
      if (c == CHAR_SEMI) semi_seen = 1'b1;
      if (trim_len == 0) begin
        star_first = (c == CHAR_STAR);
        trim_len   = 1;
      end else begin
        if (trim_len >= 2) take_middle(last_char);
        // Interior blanks are never hex digits
        if (held_spaces > 0) middle_bad = 1'b1;
        trim_len    = (trim_len + held_spaces + 1 > LEN_CAP) ? LEN_CAP
                                                             : trim_len + held_spaces + 1;
        held_spaces = 0;
      end
      last_char = c;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  function automatic int draw_gap(input bit gaps_on);
    return gaps_on ? $urandom_range(0, 10) : 0;
  endfunction

  // Send one character and predict on acceptance
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_gap(src_gaps_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_char(c);
    chars_sent++;
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_buf();
    while (line_buf.size() > 0) send_char(line_buf.pop_front());
  endtask

  task automatic send_line(input string s);
    push_str(s);
    send_buf();
  endtask

  // Hold the input idle until every queued result has come out
  task automatic wait_all_done();
    in_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sink side and result check
  // --------------------------------------------------------------------------

  function automatic string fmt_result(input line_result_t r);
    return $sformatf("status=%0d byte=%02h valid=%0b last=%0b len=%0d",
                     r.status, r.frame_byte, r.byte_valid, r.last_of_line,
                     r.frame_length);
  endfunction

  task automatic check_result();
    line_result_t got;
    line_result_t want;
    got = '{status_t'(out_ch.status), out_ch.frame_byte, out_ch.byte_valid,
            out_ch.last_of_line, out_ch.frame_length};
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %s",
               $time, fmt_result(got));
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected %s, actual %s",
                 $time, fmt_result(want), fmt_result(got));
        mismatch_count++;
      end
    end
  endtask

  // Draw a stall per result, then hold ready until a transaction happens
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = draw_gap(sink_gaps_on);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_empty_lines();
    send_line("\n");
    send_line("  \t \n");
    send_line(" *\n");
    send_line(";\r\n");
  endtask

  task automatic test_good_frames();
    send_line("*;\n");
    send_line("*00ff;\n");
    send_line("*A5bC;\r\n");
    send_line("\t *8d4840d6202cc3;  \v\f\n");
    // Largest frame that fits
    send_line("*0123456789abcdefABCDEF012345;\n");
  endtask

  task automatic test_framing_errors();
    send_line("x12;\n");
    send_line("*12\n");
    send_line("12*;\n");
    send_line(";*\n");
  endtask

  task automatic test_length_limits();
    // One byte too many
    push_str("*");
    for (int i = 0; i < 2 * MAX_BYTES + 2; i++) line_buf.push_back("7");
    push_str(";\n");
    send_buf();
    // Far past the limit so the counts saturate
    push_str("*");
    for (int i = 0; i < 3 * MAX_BYTES; i++) line_buf.push_back("e");
    push_str(";\n");
    send_buf();
  endtask

  task automatic test_bad_hex();
    send_line("*1g;\n");
    send_line("*123;\n");
    send_line("*1 2;\n");
    send_line("*12 ;\n");
    send_line("*12;;\n");
    send_line("*9:/0;\n");
    send_line("*@AF`;\n");
    send_line("*Gg;\n");
  endtask

  task automatic test_odd_bytes();
    // NUL and top-bit characters inside a frame
    push_str("*");
    line_buf.push_back(8'h00);
    push_str("1;\n");
    send_buf();
    push_str("*");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    push_str(";\n");
    send_buf();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    if ($urandom_range(0, 1)) return 8'("a" + n - 10);
    return 8'("A" + n - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return CHAR_TAB;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return CHAR_CR;
      default: return CHAR_SP;
    endcase
  endfunction

  // Fill the line buffer with one random line, mostly well formed
  function automatic void build_random_line();
    line_kind_t kind;
    int         roll;
    int         nbytes;
    int         ndigits;
    int         pos;
    roll = $urandom_range(0, 99);
    if (roll < 60)      kind = LN_GOOD;
    else if (roll < 70) kind = LN_MUTATED;
    else if (roll < 76) kind = LN_NO_SEMI;
    else if (roll < 82) kind = LN_ODD;
    else if (roll < 88) kind = LN_LONG;
    else                kind = LN_NOISE;

    if (kind == LN_NOISE) begin
      repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(CHAR_LF);
      return;
    end

    // Keep most frames short, a few near the limit
    if (kind == LN_LONG)                nbytes = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 4);
    else if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(5, MAX_BYTES);
    else                                nbytes = $urandom_range(0, 4);
    ndigits = 2 * nbytes + ((kind == LN_ODD) ? 1 : 0);

    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
    line_buf.push_back(CHAR_STAR);
    repeat (ndigits) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
    if (kind == LN_NO_SEMI) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
    else                    line_buf.push_back(CHAR_SEMI);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
    if ($urandom_range(0, 1)) line_buf.push_back(CHAR_CR);
    line_buf.push_back(CHAR_LF);

    // Corrupt one character anywhere before the newline
    if (kind == LN_MUTATED) begin
      pos = $urandom_range(0, line_buf.size() - 2);
      line_buf[pos] = 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic test_random_lines();
    int lines;
    int results_start;
    lines         = 0;
    results_start = results_predicted;
    while ((chars_sent < 250) || (results_predicted - results_start < 8)) begin
      // Switch idling on and off in stretches
      if (lines % 8 == 0) begin
        src_gaps_on  = ($urandom_range(0, 3) != 0);
        sink_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ((lines % 25) == 24) wait_all_done();
      build_random_line();
      send_buf();
      lines++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    clear_line_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_lines();
    wait_all_done();
    test_good_frames();
    test_framing_errors();
    wait_all_done();
    test_length_limits();
    test_bad_hex();
    test_odd_bytes();
    wait_all_done();
    test_random_lines();
    wait_all_done();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rhfld_pkg.sv
rtl/rhfld_in_if.sv
rtl/rhfld_out_if.sv
rtl/rhfld_byte_mem.sv
rtl/rhfld_line_parse.sv
rtl/raw_hex_frame_line_decoder.sv
tb/sv/tb_top.sv
